[rtl/core/cau_pkg.sv]
// ----------------------------------------------------------------------------
// cau_pkg: shared types for the complex arithmetic unit
// Holds the operation code shared by the operand channel interface and the core.
// ----------------------------------------------------------------------------
package cau_pkg;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_e;

endpackage

[rtl/core/cau_if.sv]
// ----------------------------------------------------------------------------
// cau_if: operand and result channels of the complex arithmetic unit
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface cau_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  cau_pkg::action_e              action;
  logic signed [DATA_WIDTH-1:0]  a_real;
  logic signed [DATA_WIDTH-1:0]  a_imag;
  logic signed [DATA_WIDTH-1:0]  b_real;
  logic signed [DATA_WIDTH-1:0]  b_imag;

  modport source (output valid, action, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, action, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  res_real;
  logic signed [DATA_WIDTH-1:0]  res_imag;
  logic                          overflow;
  logic                          div_by_zero;

  modport source (output valid, res_real, res_imag, overflow, div_by_zero, input ready);
  modport sink   (input valid, res_real, res_imag, overflow, div_by_zero, output ready);
endinterface

[rtl/core/complex_arithmetic_unit.sv]
// An input passes stages 1 to 3, the divider and the output register. Throughput:
// one item per cycle unless held; the divider is unrolled into DATA_WIDTH + 1
// restoring stages, one quotient bit per stage, so every stage takes a new item.
// The whole pipeline advances together; it holds when a result waits untaken.
// Reset (rst_ni low, asynchronous) clears all stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex add, subtract, multiply, divide
// Signed fixed point operands, saturated results, overflow and divide-by-zero.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cau_in_if.sink   in_i,
  cau_out_if.source out_o
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;          // product width
  localparam int SW = 2 * W + 1;      // sum of two products
  localparam int QW = W + 1;          // quotient bits kept
  localparam int XW = 3 * W + F + 2;  // dividend and shifted divisor
  localparam int NS = QW;             // divider stages

  // The pipeline moves as one whenever the output register is free or drained.
  logic en;
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // Stage 1: operands and the six partial products.
  logic                 v1_q;
  action_e              op1_q;
  logic signed [W-1:0]  ar1_q, ai1_q, br1_q, bi1_q;
  logic signed [PW-1:0] prr1_q, pii1_q, pir1_q, pri1_q, pbb1_q, pcc1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q  <= in_i.action;
      ar1_q  <= in_i.a_real;
      ai1_q  <= in_i.a_imag;
      br1_q  <= in_i.b_real;
      bi1_q  <= in_i.b_imag;
      prr1_q <= in_i.a_real * in_i.b_real;
      pii1_q <= in_i.a_imag * in_i.b_imag;
      pir1_q <= in_i.a_imag * in_i.b_real;
      pri1_q <= in_i.a_real * in_i.b_imag;
      pbb1_q <= in_i.b_real * in_i.b_real;
      pcc1_q <= in_i.b_imag * in_i.b_imag;
    end
  end

  // Stage 2: exact real and imaginary sums, and the squared magnitude of b.
  logic                 v2_q;
  action_e              op2_q;
  logic signed [SW-1:0] re2_d, im2_d, re2_q, im2_q;
  logic [PW-1:0]        den2_q;

  always_comb begin
    unique case (op1_q)
      ACT_ADD: begin
        re2_d = SW'(ar1_q) + SW'(br1_q);
        im2_d = SW'(ai1_q) + SW'(bi1_q);
      end
      ACT_SUB: begin
        re2_d = SW'(ar1_q) - SW'(br1_q);
        im2_d = SW'(ai1_q) - SW'(bi1_q);
      end
      ACT_MUL: begin
        re2_d = SW'(prr1_q) - SW'(pii1_q);
        im2_d = SW'(pir1_q) + SW'(pri1_q);
      end
      default: begin
        re2_d = SW'(prr1_q) + SW'(pii1_q);
        im2_d = SW'(pir1_q) - SW'(pri1_q);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q  <= op1_q;
      re2_q  <= re2_d;
      im2_q  <= im2_d;
      den2_q <= PW'(pbb1_q) + PW'(pcc1_q);
    end
  end

  // Stage 3 and the divider: index 0 is the stage 3 register, index k+1 holds
  // the item after quotient bit W-k has been decided. Sign and magnitude form
  // lets the divider work on unsigned values; rounding is toward zero.
  logic          vs_q   [NS+1];
  action_e       ops_q  [NS+1];
  logic          dzs_q  [NS+1];
  logic [PW-1:0] dens_q [NS+1];
  logic          ngr_q  [NS+1];
  logic          ngi_q  [NS+1];
  logic          ovr_q  [NS+1];
  logic          ovi_q  [NS+1];
  logic [XW-1:0] rmr_q  [NS+1];
  logic [XW-1:0] rmi_q  [NS+1];
  logic [QW-1:0] qr_q   [NS+1];
  logic [QW-1:0] qi_q   [NS+1];

  logic [SW-1:0] magr3, magi3;
  logic [XW-1:0] dvr3, dvi3, dlim3;

  always_comb begin
    magr3 = re2_q[SW-1] ? SW'(-re2_q) : SW'(re2_q);
    magi3 = im2_q[SW-1] ? SW'(-im2_q) : SW'(im2_q);
    dvr3  = XW'(magr3) << F;
    dvi3  = XW'(magi3) << F;
    dlim3 = XW'(den2_q) << QW;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q[0] <= 1'b0;
    end else if (en) begin
      vs_q[0] <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ops_q[0]  <= op2_q;
      dens_q[0] <= den2_q;
      dzs_q[0]  <= (op2_q == ACT_DIV) && (den2_q == '0);
      ngr_q[0]  <= re2_q[SW-1];
      ngi_q[0]  <= im2_q[SW-1];
      qr_q[0]   <= '0;
      qi_q[0]   <= '0;
      if (op2_q == ACT_DIV) begin
        // A quotient that would not fit the kept bits saturates in any case.
        ovr_q[0] <= dvr3 >= dlim3;
        ovi_q[0] <= dvi3 >= dlim3;
        rmr_q[0] <= dvr3;
        rmi_q[0] <= dvi3;
      end else begin
        ovr_q[0] <= 1'b0;
        ovi_q[0] <= 1'b0;
        if (op2_q == ACT_MUL) begin
          rmr_q[0] <= XW'(magr3 >> F);
          rmi_q[0] <= XW'(magi3 >> F);
        end else begin
          rmr_q[0] <= XW'(magr3);
          rmi_q[0] <= XW'(magi3);
        end
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    localparam int B = W - k;
    logic [XW-1:0] trial;
    logic          act, tk_r, tk_i;

    assign trial = XW'(dens_q[k]) << B;
    assign act   = (ops_q[k] == ACT_DIV) && !dzs_q[k];
    assign tk_r  = act && (rmr_q[k] >= trial);
    assign tk_i  = act && (rmi_q[k] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k+1] <= 1'b0;
      end else if (en) begin
        vs_q[k+1] <= vs_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ops_q[k+1]  <= ops_q[k];
        dzs_q[k+1]  <= dzs_q[k];
        dens_q[k+1] <= dens_q[k];
        ngr_q[k+1]  <= ngr_q[k];
        ngi_q[k+1]  <= ngi_q[k];
        ovr_q[k+1]  <= ovr_q[k];
        ovi_q[k+1]  <= ovi_q[k];
        rmr_q[k+1]  <= tk_r ? rmr_q[k] - trial : rmr_q[k];
        rmi_q[k+1]  <= tk_i ? rmi_q[k] - trial : rmi_q[k];
        qr_q[k+1]   <= qr_q[k] | (QW'(tk_r) << B);
        qi_q[k+1]   <= qi_q[k] | (QW'(tk_i) << B);
      end
    end
  end

  // Output register: pick the magnitude, saturate and restore the sign.
  localparam logic [XW-1:0] PosMax = XW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [XW-1:0] NegMax = XW'(64'd1 << (W - 1));

  logic [XW-1:0] mr, mi;
  logic          satr, sati, dz;
  logic [W-1:0]  resr_d, resi_d;

  always_comb begin
    dz = dzs_q[NS];
    if (ops_q[NS] == ACT_DIV) begin
      mr = ovr_q[NS] ? '1 : XW'(qr_q[NS]);
      mi = ovi_q[NS] ? '1 : XW'(qi_q[NS]);
    end else begin
      mr = rmr_q[NS];
      mi = rmi_q[NS];
    end
    if (dz) begin
      mr = '0;
      mi = '0;
    end
    satr = ngr_q[NS] ? (mr > NegMax) : (mr > PosMax);
    sati = ngi_q[NS] ? (mi > NegMax) : (mi > PosMax);
    if (ngr_q[NS]) begin
      resr_d = satr ? W'(NegMax) : W'(-mr);
    end else begin
      resr_d = satr ? W'(PosMax) : W'(mr);
    end
    if (ngi_q[NS]) begin
      resi_d = sati ? W'(NegMax) : W'(-mi);
    end else begin
      resi_d = sati ? W'(PosMax) : W'(mi);
    end
  end

  logic          ov_q, dz_q;
  logic [W-1:0]  resr_q, resi_q;
  logic          vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= vs_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      resr_q <= resr_d;
      resi_q <= resi_d;
      ov_q   <= satr || sati;
      dz_q   <= dz;
    end
  end

  assign out_o.valid       = vo_q;
  assign out_o.res_real    = resr_q;
  assign out_o.res_imag    = resi_q;
  assign out_o.overflow    = ov_q;
  assign out_o.div_by_zero = dz_q;

endmodule
